// ===== rtl/ipv4p_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ipv4p_pkg: shared types and constants for the ipv4 address and netmask parser
// used by ipv4p_text and ipv4_address_and_netmask_parser_top; no dependencies

package ipv4p_pkg;

   // action codes of an input item
   typedef enum logic [1:0] {
      ACT_ADDR_CHAR = 2'd0,
      ACT_MASK_CHAR = 2'd1,
      ACT_ADDR_WORD = 2'd2,
      ACT_MASK_WORD = 2'd3
   } action_type;

   localparam logic [7:0]  CHAR_ZERO      = 8'h30;
   localparam logic [7:0]  CHAR_NINE      = 8'h39;
   localparam logic [7:0]  CHAR_DOT       = 8'h2E;
   localparam logic [8:0]  FIELD_MAX      = 9'd255;
   localparam logic [8:0]  FIELD_SAT      = 9'd256;
   localparam logic [1:0]  LAST_DOT       = 2'd3;
   localparam logic [31:0] LOCALHOST_ADDR = 32'h7F00_0001;

   typedef struct packed {
      action_type  action;
      logic [7:0]  character;
      logic        last;
      logic [31:0] word;
   } req_type;

   typedef struct packed {
      logic        ok;
      logic        address_valid;
      logic [31:0] address_value;
      logic        mask_known;
      logic [5:0]  prefix_length;
      logic [31:0] mask_value;
      logic [31:0] broadcast;
      logic        is_localhost;
   } rsp_type;

   // outcome of a text once its final character has been taken
   typedef struct packed {
      logic        ok;
      logic [31:0] value;
   } parse_type;

endpackage

`default_nettype wire

// ===== rtl/ipv4p_text.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ipv4p_text: dotted-quad text parser, one character per step
// depends on ipv4p_pkg

module ipv4p_text
   import ipv4p_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       step,
   input  wire logic [7:0] character,
   input  wire logic       last,
   output parse_type       result
);

   logic        in_field_ff, in_field_in;
   logic [1:0]  dot_count_ff, dot_count_in;
   logic [8:0]  acc_ff, acc_in;
   logic [23:0] octets_ff, octets_in;
   logic        failed_ff, failed_in;

   logic        digit;
   logic [3:0]  digit_value;
   logic [11:0] acc_times_ten;
   logic        text_ok;

   assign digit         = (character >= CHAR_ZERO) && (character <= CHAR_NINE);
   assign digit_value   = character[3:0];
   assign acc_times_ten = {3'b000, acc_ff} * 12'd10 + {8'h00, digit_value};

   // parser state after this character
   always_comb begin
      in_field_in  = in_field_ff;
      dot_count_in = dot_count_ff;
      acc_in       = acc_ff;
      octets_in    = octets_ff;
      failed_in    = failed_ff;
      if (!failed_ff) begin
         if (!in_field_ff) begin
            if (digit) begin
               in_field_in = 1'b1;
               acc_in      = {5'b00000, digit_value};
            end else begin
               failed_in = 1'b1;
            end
         end else if (character == CHAR_DOT) begin
            if (acc_ff > FIELD_MAX || dot_count_ff == LAST_DOT) begin
               failed_in = 1'b1;
            end else begin
               octets_in    = {octets_ff[15:0], acc_ff[7:0]};
               dot_count_in = dot_count_ff + 2'd1;
               in_field_in  = 1'b0;
               acc_in       = '0;
            end
         end else if (digit) begin
            // saturate so an oversized field stays above the limit
            acc_in = (acc_times_ten > {3'b000, FIELD_SAT}) ? FIELD_SAT : acc_times_ten[8:0];
         end else begin
            failed_in = 1'b1;
         end
      end
   end

   // verdict on the text if this is its final character
   assign text_ok = !failed_in && in_field_in && (dot_count_in == LAST_DOT) &&
                    (acc_in <= FIELD_MAX);
   // ok flag on top, then the four octets
   assign result  = {text_ok, octets_in, acc_in[7:0]};

   // parser registers, cleared at the end of every text
   always_ff @(posedge clock) begin
      if (reset || (step && last)) begin
         in_field_ff  <= 1'b0;
         dot_count_ff <= '0;
         acc_ff       <= '0;
         octets_ff    <= '0;
         failed_ff    <= 1'b0;
      end else if (step) begin
         in_field_ff  <= in_field_in;
         dot_count_ff <= dot_count_in;
         acc_ff       <= acc_in;
         octets_ff    <= octets_in;
         failed_ff    <= failed_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/ipv4_address_and_netmask_parser_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ipv4_address_and_netmask_parser_top: address and netmask store with text parser
// depends on ipv4p_pkg and ipv4p_text
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_ready  req_data (req_type)
//   rsp      out        rsp_valid / rsp_ready  rsp_data (rsp_type)
//
// one item per cycle sustained while results are taken; an item waits in the input register
// until the output register has room, and its result is then written into the output register
// characters without the last flag give no result and only advance the parser
// synchronous reset clears the stored address, netmask, parser and both registers
// a held result stalls the input register, which still takes a new item as it drains

module ipv4_address_and_netmask_parser_top
   import ipv4p_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic      req_ready,
   input  req_type   req_data,
   output logic      rsp_valid,
   input  wire logic rsp_ready,
   output rsp_type   rsp_data
);

   req_type     item_ff;
   logic        item_valid_ff;
   logic        fire;

   logic [31:0] addr_ff, addr_in;
   logic        addr_ok_ff, addr_ok_in;
   logic [31:0] mask_ff, mask_in;
   logic [5:0]  prefix_ff, prefix_in;
   logic        mask_set_ff, mask_set_in;

   logic        rsp_valid_ff;
   rsp_type     rsp_ff, rsp_in;

   logic        text_step;
   logic        produce;
   logic        item_ok;
   logic        set_mask;
   logic [31:0] mask_source;
   logic [31:0] mask_run;
   parse_type   parse;

   // stage advances whenever the output register has room
   assign fire      = item_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !item_valid_ff || fire;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (req_ready) begin
         item_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= req_data;
      end
   end

   assign text_step = fire && (item_ff.action == ACT_ADDR_CHAR ||
                               item_ff.action == ACT_MASK_CHAR);

   ipv4p_text u_text (
      .clock     (clock),
      .reset     (reset),
      .step      (text_step),
      .character (item_ff.character),
      .last      (item_ff.last),
      .result    (parse)
   );

   // decode the item and work out the stored state it leaves
   always_comb begin
      addr_in     = addr_ff;
      addr_ok_in  = addr_ok_ff;
      set_mask    = 1'b0;
      mask_source = item_ff.word;
      produce     = 1'b1;
      item_ok     = 1'b1;
      unique case (item_ff.action)
         ACT_ADDR_WORD: begin
            addr_in    = item_ff.word;
            addr_ok_in = 1'b1;
         end
         ACT_MASK_WORD: begin
            set_mask = 1'b1;
         end
         ACT_ADDR_CHAR: begin
            produce = item_ff.last;
            item_ok = parse.ok;
            if (parse.ok) begin
               addr_in = parse.value;
            end
            addr_ok_in = parse.ok;
         end
         ACT_MASK_CHAR: begin
            produce     = item_ff.last;
            item_ok     = parse.ok;
            set_mask    = parse.ok;
            mask_source = parse.value;
         end
         default: begin
            produce = 1'b0;
         end
      endcase
   end

   // leading run of ones, as a mask and as its length
   always_comb begin
      mask_run = '0;
      mask_run[31] = mask_source[31];
      for (int i = 30; i >= 0; i--) begin
         mask_run[i] = mask_run[i + 1] & mask_source[i];
      end
   end

   assign mask_in     = set_mask ? mask_run : mask_ff;
   assign prefix_in   = set_mask ? 6'($countones(mask_run)) : prefix_ff;
   assign mask_set_in = mask_set_ff | set_mask;

   // result fields from the state after the item
   always_comb begin
      rsp_in.ok            = item_ok;
      rsp_in.address_valid = addr_ok_in;
      rsp_in.address_value = addr_in;
      rsp_in.mask_known    = mask_set_in;
      rsp_in.prefix_length = prefix_in;
      rsp_in.mask_value    = mask_in;
      rsp_in.broadcast     = (addr_ok_in && mask_set_in) ? ((addr_in & mask_in) | ~mask_in)
                                                         : '0;
      rsp_in.is_localhost  = addr_ok_in && (addr_in == LOCALHOST_ADDR);
   end

   // stored address and netmask
   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff     <= '0;
         addr_ok_ff  <= 1'b0;
         mask_ff     <= '0;
         prefix_ff   <= '0;
         mask_set_ff <= 1'b0;
      end else if (fire && produce) begin
         addr_ff     <= addr_in;
         addr_ok_ff  <= addr_ok_in;
         mask_ff     <= mask_in;
         prefix_ff   <= prefix_in;
         mask_set_ff <= mask_set_in;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire && produce) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && produce) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // checks on the result contents
   a_localhost_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.is_localhost |-> rsp_ff.address_valid)
      else $error("localhost flag without a valid address");

   a_prefix_matches_mask: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ($countones(rsp_ff.mask_value) == int'(rsp_ff.prefix_length)))
      else $error("prefix length disagrees with mask");

   a_broadcast_gated: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !(rsp_ff.address_valid && rsp_ff.mask_known)
         |-> rsp_ff.broadcast == '0)
      else $error("broadcast without address and mask");

   a_no_mask_before_set: assert property (@(posedge clock) disable iff (reset)
      !mask_set_ff |-> (mask_ff == '0 && prefix_ff == '0))
      else $error("mask state changed without a mask write");

endmodule

`default_nettype wire

// ===== bench/ipv4p_score_pkg.sv =====
`timescale 1ns / 1ps
// ipv4p_score_pkg: scoreboard for the ipv4 address and netmask parser bench
// holds its own copy of the stored address, netmask and text parser state
// depends on ipv4p_pkg for the transfer types, action codes and constants

package ipv4p_score_pkg;
   import ipv4p_pkg::*;

   class ipv4p_scoreboard;
      rsp_type     expected_views[$];
      int          errors = 0;

      // stored address and netmask
      logic [31:0] addr_word = '0;
      bit          addr_ok = 1'b0;
      logic [5:0]  prefix_len = '0;
      bit          prefix_known = 1'b0;

      // dotted-quad text parser
      bit          in_field = 1'b0;
      logic [1:0]  dots = '0;
      int          field_value = 0;
      logic [23:0] octets = '0;
      bit          text_bad = 1'b0;

      static function logic [5:0] count_leading_ones(logic [31:0] w);
         logic [5:0] n;
         n = '0;
         for (int i = 31; i >= 0 && w[i]; i--) n++;
         return n;
      endfunction

      function int pending();
         return expected_views.size();
      endfunction

      // predict the view after one accepted input transfer
      function void note_item(req_type item);
         rsp_type     view;
         logic [31:0] mask;
         bit          digit;
         bit          good;
         int          sum;
         good = 1'b0;
         case (item.action)
            ACT_ADDR_WORD: begin
               addr_word = item.word;
               addr_ok = 1'b1;
               good = 1'b1;
            end
            ACT_MASK_WORD: begin
               prefix_len = count_leading_ones(item.word);
               prefix_known = 1'b1;
               good = 1'b1;
            end
            default: begin
               digit = item.character >= CHAR_ZERO && item.character <= CHAR_NINE;
               // once a text has failed, the rest of it is ignored
               if (!text_bad) begin
                  if (!in_field) begin
                     if (digit) begin
                        in_field = 1'b1;
                        field_value = item.character - CHAR_ZERO;
                     end else begin
                        text_bad = 1'b1;
                     end
                  end else if (item.character == CHAR_DOT) begin
                     if (field_value > FIELD_MAX || dots == LAST_DOT) begin
                        text_bad = 1'b1;
                     end else begin
                        octets = {octets[15:0], field_value[7:0]};
                        dots++;
                        in_field = 1'b0;
                        field_value = 0;
                     end
                  end else if (digit) begin
                     // accumulator saturates just above the largest octet
                     sum = field_value * 10 + (item.character - CHAR_ZERO);
                     field_value = (sum > FIELD_SAT) ? FIELD_SAT : sum;
                  end else begin
                     text_bad = 1'b1;
                  end
               end
               if (!item.last) return;
               good = !text_bad && in_field && dots == LAST_DOT && field_value <= FIELD_MAX;
               // the action of the final character picks the target
               if (good) begin
                  if (item.action == ACT_ADDR_CHAR) begin
                     addr_word = {octets, field_value[7:0]};
                     addr_ok = 1'b1;
                  end else begin
                     prefix_len = count_leading_ones({octets, field_value[7:0]});
                     prefix_known = 1'b1;
                  end
               end else if (item.action == ACT_ADDR_CHAR) begin
                  addr_ok = 1'b0;
               end
               in_field = 1'b0;
               dots = '0;
               field_value = 0;
               octets = '0;
               text_bad = 1'b0;
            end
         endcase

         mask = (prefix_known && prefix_len != 0) ? (32'hFFFF_FFFF << (32 - prefix_len)) : '0;
         view.ok = good;
         view.address_valid = addr_ok;
         view.address_value = addr_word;
         view.mask_known = prefix_known;
         view.prefix_length = prefix_known ? prefix_len : '0;
         view.mask_value = mask;
         view.broadcast = (addr_ok && prefix_known) ? ((addr_word & mask) | ~mask) : '0;
         view.is_localhost = addr_ok && addr_word == LOCALHOST_ADDR;
         expected_views.push_back(view);
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
         end
      endfunction

      // compare one result transfer with the oldest prediction
      function void check_view(rsp_type got);
         rsp_type want;
         if (expected_views.size() == 0) begin
            $error("result transfer with no prediction waiting");
            errors++;
            return;
         end
         want = expected_views.pop_front();
         compare_field("ok", want.ok, got.ok);
         compare_field("address_valid", want.address_valid, got.address_valid);
         compare_field("address_value", want.address_value, got.address_value);
         compare_field("mask_known", want.mask_known, got.mask_known);
         compare_field("prefix_length", want.prefix_length, got.prefix_length);
         compare_field("mask_value", want.mask_value, got.mask_value);
         compare_field("broadcast", want.broadcast, got.broadcast);
         compare_field("is_localhost", want.is_localhost, got.is_localhost);
      endfunction
   endclass

endpackage

// ===== bench/tb_ipv4_address_and_netmask_parser_top.sv =====
`timescale 1ns / 1ps
// tb_ipv4_address_and_netmask_parser_top: drives dotted-quad texts and word writes
// into the parser and checks every result against the scoreboard's prediction
// depends on ipv4p_pkg, ipv4p_score_pkg and ipv4_address_and_netmask_parser_top

module tb_ipv4_address_and_netmask_parser_top;
   import ipv4p_pkg::*;
   import ipv4p_score_pkg::*;

   typedef logic [7:0] char_list[$];

   localparam int RANDOM_ITEMS = 950;
   localparam int HOLD_CYCLES  = 200;
   localparam int CYCLE_LIMIT  = 150000;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   ipv4p_scoreboard board = new();
   int items_sent = 0;
   int cycle_count = 0;
   bit gappy = 1'b0;
   bit calm = 1'b0;
   bit hold_request = 1'b0;

   ipv4_address_and_netmask_parser_top DUT (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // observe transfers on both channels
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) board.note_item(req_data);
         if (rsp_valid && rsp_ready) board.check_view(rsp_data);
      end
   end

   // result side: random stalls, one long hold-off, none in the final stretch
   initial begin
      rsp_ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (hold_request) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_request = 1'b0;
         end else if (calm || $urandom_range(0, 2) != 0) begin
            rsp_ready <= 1'b1;
            repeat (calm ? 1 : $urandom_range(1, 20)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clock);
         end
      end
   end

   function automatic char_list to_chars(string s);
      char_list q;
      for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
      return q;
   endfunction

   // one input transfer, with an occasional gap before it
   task automatic send_item(req_type item);
      if (gappy && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   task automatic send_word(action_type act, logic [31:0] w);
      req_type item;
      item.action = act;
      item.character = $urandom_range(0, 255);
      item.last = $urandom_range(0, 1);
      item.word = w;
      send_item(item);
   endtask

   function automatic logic [31:0] random_mask();
      int p;
      logic [31:0] m;
      p = $urandom_range(0, 32);
      m = (p == 0) ? '0 : (32'hFFFF_FFFF << (32 - p));
      // now and then a mask with holes
      if ($urandom_range(0, 4) == 0) m ^= $urandom;
      return m;
   endfunction

   // characters of one text; may mix actions or carry a word write midway
   task automatic send_text(char_list chars, action_type act, bit mixed, bit word_mid);
      req_type item;
      action_type other;
      other = (act == ACT_ADDR_CHAR) ? ACT_MASK_CHAR : ACT_ADDR_CHAR;
      foreach (chars[i]) begin
         if (word_mid && i == chars.size() / 2)
            send_word($urandom_range(0, 1) ? ACT_ADDR_WORD : ACT_MASK_WORD, $urandom);
         item.action = (mixed && $urandom_range(0, 1)) ? other : act;
         item.character = chars[i];
         item.last = (i == chars.size() - 1);
         item.word = $urandom;
         send_item(item);
      end
   endtask

   // mostly well-formed dotted quads, the rest broken in the usual ways
   task automatic send_random_text();
      string fields[4];
      string text;
      char_list chars;
      logic [31:0] value;
      action_type act;
      int kind;
      int pick;
      act = $urandom_range(0, 1) ? ACT_MASK_CHAR : ACT_ADDR_CHAR;
      if (act == ACT_MASK_CHAR) value = random_mask();
      else if ($urandom_range(0, 9) == 0) value = LOCALHOST_ADDR;
      else value = $urandom;
      foreach (fields[i]) begin
         fields[i] = $sformatf("%0d", value[31 - 8 * i -: 8]);
         if ($urandom_range(0, 5) == 0)
            repeat ($urandom_range(1, 2)) fields[i] = {"0", fields[i]};
      end
      pick = $urandom_range(0, 3);
      kind = $urandom_range(0, 99);
      if (kind >= 94) begin
         // random bytes
         repeat ($urandom_range(1, 8)) chars.push_back($urandom_range(0, 255));
      end else begin
         if (kind >= 65 && kind < 70)
            fields[pick] = $sformatf("%0d", $urandom_range(256, 99999));
         else if (kind >= 70 && kind < 74)
            fields[pick] = "";
         text = {fields[0], ".", fields[1], ".", fields[2], ".", fields[3]};
         if (kind >= 74 && kind < 78)
            text = {text, ".", $sformatf("%0d", $urandom_range(0, 255))};
         else if (kind >= 78 && kind < 82)
            text = {fields[0], ".", fields[1], ".", fields[2]};
         chars = to_chars(text);
         if (kind >= 82 && kind < 88)
            chars.push_back($urandom_range(0, 255));
         else if (kind >= 88)
            chars[$urandom_range(0, chars.size() - 1)] = $urandom_range(0, 255);
      end
      send_text(chars, act, $urandom_range(0, 9) == 0, $urandom_range(0, 19) == 0);
   endtask

   // stop offering and wait for every predicted result
   task automatic await_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.pending() != 0) @(posedge clock);
   endtask

   // stimulus
   initial begin
      bit hold_done;
      bit pause_done;
      hold_done = 1'b0;
      pause_done = 1'b0;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: word extremes, a mask with holes, localhost, a failed mask text
      send_word(ACT_MASK_WORD, 32'hFFFF_FFFF);
      send_word(ACT_ADDR_WORD, 32'hFFFF_FFFF);
      send_word(ACT_MASK_WORD, 32'h0000_0000);
      send_word(ACT_ADDR_WORD, 32'h0000_0000);
      send_word(ACT_MASK_WORD, 32'hFF00_FF00);
      send_text(to_chars("127.0.0.1"), ACT_ADDR_CHAR, 1'b0, 1'b0);
      send_text(to_chars("9.9"), ACT_MASK_CHAR, 1'b0, 1'b0);

      // random part
      while (items_sent < RANDOM_ITEMS) begin
         if (!hold_done && items_sent >= 300) begin
            // keep offering results while the receiver holds off
            hold_done = 1'b1;
            gappy = 1'b0;
            hold_request = 1'b1;
            repeat (24)
               send_word($urandom_range(0, 1) ? ACT_ADDR_WORD : ACT_MASK_WORD, $urandom);
         end
         if (!pause_done && items_sent >= 600) begin
            pause_done = 1'b1;
            await_results();
         end
         calm = items_sent >= 850;
         gappy = !calm && $urandom_range(0, 4) < 3;
         if ($urandom_range(0, 6) == 0) begin
            if ($urandom_range(0, 1)) send_word(ACT_ADDR_WORD, $urandom);
            else send_word(ACT_MASK_WORD, $urandom_range(0, 1) ? random_mask() : $urandom);
         end else begin
            send_random_text();
         end
      end

      await_results();
      repeat (10) @(posedge clock);
      if (board.errors == 0 && board.pending() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
